### design/ers_pkg.sv
// ----------------------------------------------------------------------------
// Elevator request scheduler package
// Shared constants for the two sorted call queues and the stream payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int FLOOR_COUNT = 64;

  localparam int FLOOR_W = 6;
  localparam int DEST_W  = 7;
  localparam int COUNT_W = 7;
  localparam int ENTRY_W = FLOOR_W + DEST_W;

  // Floors at or above this value are rejected.
  localparam logic [8:0] FLOOR_LIMIT = 9'(FLOOR_COUNT);

  localparam logic [1:0] OP_UP_CALL   = 2'd0;
  localparam logic [1:0] OP_DOWN_CALL = 2'd1;
  localparam logic [1:0] OP_SERVE     = 2'd2;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_MOVED     = 3'd3;
  localparam logic [2:0] ST_NOTHING   = 3'd4;

  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_IDLE = 2'd2;

  localparam logic QSEL_UP   = 1'b0;
  localparam logic QSEL_DOWN = 1'b1;

endpackage

`default_nettype wire

### design/ers_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ers_ram #(
  parameter int WIDTH = ers_pkg::ENTRY_W,
  parameter int DEPTH = ers_pkg::QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/elevator_request_scheduler.sv
// ----------------------------------------------------------------------------
// Elevator request scheduler
// Two sorted call queues (up and down) with a scan-style serve step.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser opcode, tdata call and destination
// m_*       out        m_tvalid/m_tready  tdata status, floors, direction, counts
//
// A call request makes one RAM read per queued entry to find the slot, then
// one move per entry above it. A serve request pops the last entry of its
// queue, plus one insertion when its destination is queued. Reset is
// synchronous and needs no clearing pass over the queues.
// The block accepts the next request while a result still waits on m_*.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_request_scheduler #(
  parameter int QUEUE_DEPTH = ers_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // call_floor[5:0], dest_floor[11:6], dest_valid[12]
  input  wire logic [1:0]  s_tuser,  // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // status[2:0], from_floor[8:3], to_floor[14:9],
                                     // travel_dir[16:15], up_pending[23:17],
                                     // down_pending[30:24]
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = ers_pkg::FLOOR_W;
  localparam int CW = ers_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SHIFT    = 3'd2;
  localparam logic [2:0] S_INSERT   = 3'd3;
  localparam logic [2:0] S_POP_RD   = 3'd4;
  localparam logic [2:0] S_POP_DATA = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]    state;
  logic [FW-1:0] car_floor;
  logic [1:0]    car_dir;
  logic [CW-1:0] up_count;
  logic [CW-1:0] down_count;
  logic          sel;
  logic          internal;
  logic          srv;
  logic          srv_sel;
  logic [FW-1:0] ins_floor;
  logic [ers_pkg::DEST_W-1:0] ins_dest;
  logic [2:0]    status;
  logic [FW-1:0] from_floor;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic          pend;
  logic          wpend;
  logic [AW-1:0] waddr;

  logic [CW-1:0] n;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [ers_pkg::ENTRY_W-1:0] wr_data;
  logic [ers_pkg::ENTRY_W-1:0] up_rd;
  logic [ers_pkg::ENTRY_W-1:0] down_rd;
  logic [ers_pkg::ENTRY_W-1:0] rd_data;
  logic [FW-1:0] rd_floor;
  logic [ers_pkg::DEST_W-1:0] rd_dest;
  logic [FW-1:0] cmp_a;
  logic          lt;
  logic          eq;
  logic          stop;
  logic          up_live;
  logic          down_live;
  logic          stale;
  logic          go_up;
  logic          go_down;
  logic [1:0]    dir_out;
  logic          out_free;
  logic [ers_pkg::DEST_W-1:0] req_dest;

  assign n        = sel ? down_count : up_count;
  assign rd_data  = sel ? down_rd : up_rd;
  assign rd_floor = rd_data[FW-1:0];
  assign rd_dest  = rd_data[ers_pkg::ENTRY_W-1:FW];

  // Shared comparator: the queued floor against the new floor or the destination.
  assign cmp_a = (state == S_POP_DATA) ? rd_dest[FW-1:0] : ins_floor;
  assign lt    = cmp_a < rd_floor;
  assign eq    = cmp_a == rd_floor;
  assign stop  = pend && ((sel == ers_pkg::QSEL_UP) ? !lt : (lt || eq));

  assign up_live   = up_count != '0;
  assign down_live = down_count != '0;
  assign stale     = !((car_dir == ers_pkg::DIR_UP && up_live) ||
                       (car_dir == ers_pkg::DIR_DOWN && down_live));
  assign go_up     = up_live && (car_dir == ers_pkg::DIR_UP || stale);
  assign go_down   = down_live && ((car_dir == ers_pkg::DIR_DOWN && !stale) ||
                                   (stale && !up_live));

  assign dir_out  = (srv && ((srv_sel ? down_count : up_count) == '0)) ?
                    ers_pkg::DIR_IDLE : car_dir;
  assign out_free = !m_tvalid || m_tready;
  assign req_dest = s_tdata[12] ? {1'b1, s_tdata[11:6]} : '0;
  assign s_tready = state == S_IDLE;

  always_comb begin
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = waddr;
    wr_data = rd_data;
    unique case (state)
      S_SHIFT: begin
        rd_addr = AW'(idx - 1'b1);
        wr_en   = wpend;
      end
      S_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = pos[AW-1:0];
        wr_data = {ins_dest, ins_floor};
      end
      S_POP_RD: begin
        rd_addr = n[AW-1:0];
      end
      default: begin
        rd_addr = idx[AW-1:0];
      end
    endcase
  end

  ers_ram #(
    .WIDTH (ers_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_up_ram (
    .clk     (clk),
    .wr_en   (wr_en && (sel == ers_pkg::QSEL_UP)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (up_rd)
  );

  ers_ram #(
    .WIDTH (ers_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_down_ram (
    .clk     (clk),
    .wr_en   (wr_en && (sel == ers_pkg::QSEL_DOWN)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (down_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      car_floor  <= '0;
      car_dir    <= ers_pkg::DIR_IDLE;
      up_count   <= '0;
      down_count <= '0;
      m_tvalid   <= 1'b0;
      srv        <= 1'b0;
      internal   <= 1'b0;
      pend       <= 1'b0;
      wpend      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            from_floor <= car_floor;
            internal   <= 1'b0;
            srv        <= 1'b0;
            idx        <= '0;
            pend       <= 1'b0;
            ins_floor  <= s_tdata[5:0];
            ins_dest   <= req_dest;
            unique case (s_tuser) inside
              ers_pkg::OP_UP_CALL, ers_pkg::OP_DOWN_CALL: begin
                sel <= (s_tuser == ers_pkg::OP_DOWN_CALL);
                if ({3'b000, s_tdata[5:0]} >= ers_pkg::FLOOR_LIMIT) begin
                  status <= ers_pkg::ST_RANGE;
                  state  <= S_DONE;
                end else begin
                  status <= ers_pkg::ST_QUEUED;
                  state  <= S_SCAN;
                end
              end
              ers_pkg::OP_SERVE: begin
                status <= ers_pkg::ST_MOVED;
                if (go_up) begin
                  car_dir  <= ers_pkg::DIR_UP;
                  up_count <= up_count - 1'b1;
                  sel      <= ers_pkg::QSEL_UP;
                  srv_sel  <= ers_pkg::QSEL_UP;
                  srv      <= 1'b1;
                  state    <= S_POP_RD;
                end else if (go_down) begin
                  car_dir    <= ers_pkg::DIR_DOWN;
                  down_count <= down_count - 1'b1;
                  sel        <= ers_pkg::QSEL_DOWN;
                  srv_sel    <= ers_pkg::QSEL_DOWN;
                  srv        <= 1'b1;
                  state      <= S_POP_RD;
                end else begin
                  car_dir <= ers_pkg::DIR_IDLE;
                  status  <= ers_pkg::ST_NOTHING;
                  state   <= S_DONE;
                end
              end
              default: begin
                status <= ers_pkg::ST_NOTHING;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (stop && eq) begin
            if (!internal) begin
              status <= ers_pkg::ST_DUPLICATE;
            end
            state <= S_DONE;
          end else if (stop || idx == n) begin
            if (n >= CW'(QUEUE_DEPTH)) begin
              if (!internal) begin
                status <= ers_pkg::ST_DUPLICATE;
              end
              state <= S_DONE;
            end else begin
              pos   <= stop ? idx - 1'b1 : idx;
              idx   <= n;
              wpend <= 1'b0;
              state <= S_SHIFT;
            end
          end else begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end
        end
        S_SHIFT: begin
          if (idx != pos) begin
            waddr <= idx[AW-1:0];
            wpend <= 1'b1;
            idx   <= idx - 1'b1;
          end else begin
            wpend <= 1'b0;
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (sel == ers_pkg::QSEL_DOWN) begin
            down_count <= down_count + 1'b1;
          end else begin
            up_count <= up_count + 1'b1;
          end
          state <= S_DONE;
        end
        S_POP_RD: begin
          state <= S_POP_DATA;
        end
        S_POP_DATA: begin
          car_floor <= rd_floor;
          if (rd_dest[ers_pkg::DEST_W-1] && !eq &&
              ({3'b000, rd_dest[FW-1:0]} < ers_pkg::FLOOR_LIMIT)) begin
            sel       <= lt ? ers_pkg::QSEL_DOWN : ers_pkg::QSEL_UP;
            ins_floor <= rd_dest[FW-1:0];
            ins_dest  <= '0;
            internal  <= 1'b1;
            idx       <= '0;
            pend      <= 1'b0;
            state     <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            car_dir  <= dir_out;
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, down_count, up_count, dir_out, car_floor, from_floor,
                         status};
            srv      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/elevator_request_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Elevator request scheduler testbench
// Sends up calls, down calls, serve steps and unused opcodes on the input stream.
// A model of the two sorted call queues predicts each result that the script
// does not fix. Results are compared field by field in order. Input runs in
// bursts and output stalls. The receiver holds off once for a long stretch and
// the sender once waits for all results. Each queue is filled to full depth.
// ----------------------------------------------------------------------------
module elevator_request_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1100;
  localparam int SETTLE_AT = 500;
  localparam int HOLD_OFF_AFTER = 700;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] call;
    logic [5:0] dest;
    logic       dval;
  } call_item_t;

  // Same layout as m_tdata[30:0].
  typedef struct packed {
    logic [6:0] down_pending;
    logic [6:0] up_pending;
    logic [1:0] travel_dir;
    logic [5:0] to_floor;
    logic [5:0] from_floor;
    logic [2:0] status;
  } move_report_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [5:0]   call;
    logic [5:0]   dest;
    logic         dval;
    logic         typed;
    move_report_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  logic [5:0] q_floor [2][ers_pkg::QUEUE_DEPTH];
  logic [6:0] q_dest [2][ers_pkg::QUEUE_DEPTH];
  int         q_len [2];
  logic [5:0] car_floor_m;
  logic [1:0] car_dir_m;

  move_report_t awaited_reports[$];
  int mismatches = 0;
  int accepted_requests = 0;
  int burst_left = 0;

  // Columns: op, call, dest, dval, typed, {down, up, dir, to, from, status}.
  script_row_t script [23] = '{
    '{ers_pkg::OP_SERVE, 6'd0, 6'd0, 1'b0, 1'b1,
      '{7'd0, 7'd0, ers_pkg::DIR_IDLE, 6'd0, 6'd0, ers_pkg::ST_NOTHING}},
    '{OP_UNUSED, 6'd63, 6'd63, 1'b1, 1'b1,
      '{7'd0, 7'd0, ers_pkg::DIR_IDLE, 6'd0, 6'd0, ers_pkg::ST_NOTHING}},
    '{ers_pkg::OP_UP_CALL, 6'd0, 6'd63, 1'b1, 1'b1,
      '{7'd0, 7'd1, ers_pkg::DIR_IDLE, 6'd0, 6'd0, ers_pkg::ST_QUEUED}},
    '{ers_pkg::OP_UP_CALL, 6'd63, 6'd0, 1'b1, 1'b1,
      '{7'd0, 7'd2, ers_pkg::DIR_IDLE, 6'd0, 6'd0, ers_pkg::ST_QUEUED}},
    '{ers_pkg::OP_UP_CALL, 6'd0, 6'd21, 1'b1, 1'b1,
      '{7'd0, 7'd2, ers_pkg::DIR_IDLE, 6'd0, 6'd0, ers_pkg::ST_DUPLICATE}},
    '{ers_pkg::OP_DOWN_CALL, 6'd63, 6'd0, 1'b0, 1'b1,
      '{7'd1, 7'd2, ers_pkg::DIR_IDLE, 6'd0, 6'd0, ers_pkg::ST_QUEUED}},
    '{ers_pkg::OP_DOWN_CALL, 6'd0, 6'd63, 1'b1, 1'b1,
      '{7'd2, 7'd2, ers_pkg::DIR_IDLE, 6'd0, 6'd0, ers_pkg::ST_QUEUED}},
    '{ers_pkg::OP_DOWN_CALL, 6'd63, 6'd42, 1'b1, 1'b1,
      '{7'd2, 7'd2, ers_pkg::DIR_IDLE, 6'd0, 6'd0, ers_pkg::ST_DUPLICATE}},
    '{ers_pkg::OP_UP_CALL,   6'd30, 6'd30, 1'b1, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{OP_UNUSED,             6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_UP_CALL,   6'd42, 6'd21, 1'b1, 1'b0, '0},
    '{ers_pkg::OP_DOWN_CALL, 6'd21, 6'd42, 1'b1, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0},
    '{ers_pkg::OP_SERVE,     6'd0,  6'd0,  1'b0, 1'b0, '0}
  };

  elevator_request_scheduler DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The up queue is kept largest first and the down queue smallest first, so
  // the entry to serve next is always the last one.
  function automatic logic [2:0] insert_call(logic qsel, logic [5:0] fl, logic [6:0] dest);
    int n;
    int pos;
    n = q_len[qsel];
    if (int'(fl) >= ers_pkg::FLOOR_COUNT) return ers_pkg::ST_RANGE;
    for (int i = 0; i < n; i++)
      if (q_floor[qsel][i] == fl) return ers_pkg::ST_DUPLICATE;
    if (n >= ers_pkg::QUEUE_DEPTH) return ers_pkg::ST_DUPLICATE;
    pos = n;
    for (int i = 0; i < n; i++) begin
      if ((qsel == ers_pkg::QSEL_UP) ? (fl > q_floor[qsel][i]) :
                                       (fl < q_floor[qsel][i])) begin
        pos = i;
        break;
      end
    end
    for (int i = n; i > pos; i--) begin
      q_floor[qsel][i] = q_floor[qsel][i - 1];
      q_dest[qsel][i] = q_dest[qsel][i - 1];
    end
    q_floor[qsel][pos] = fl;
    q_dest[qsel][pos] = dest;
    q_len[qsel] = n + 1;
    return ers_pkg::ST_QUEUED;
  endfunction

  function automatic move_report_t schedule_step(call_item_t it);
    move_report_t r;
    logic [6:0] dest_word;
    logic [6:0] served;
    logic qsel;
    dest_word = it.dval ? {1'b1, it.dest} : 7'd0;
    r.from_floor = car_floor_m;
    case (it.op)
      ers_pkg::OP_UP_CALL: r.status = insert_call(ers_pkg::QSEL_UP, it.call, dest_word);
      ers_pkg::OP_DOWN_CALL: r.status = insert_call(ers_pkg::QSEL_DOWN, it.call, dest_word);
      ers_pkg::OP_SERVE: begin
        if (car_dir_m > ers_pkg::DIR_IDLE ||
            (car_dir_m == ers_pkg::DIR_UP && q_len[ers_pkg::QSEL_UP] == 0) ||
            (car_dir_m == ers_pkg::DIR_DOWN && q_len[ers_pkg::QSEL_DOWN] == 0))
          car_dir_m = ers_pkg::DIR_IDLE;
        if (car_dir_m == ers_pkg::DIR_IDLE) begin
          if (q_len[ers_pkg::QSEL_UP] > 0) car_dir_m = ers_pkg::DIR_UP;
          else if (q_len[ers_pkg::QSEL_DOWN] > 0) car_dir_m = ers_pkg::DIR_DOWN;
        end
        if (car_dir_m == ers_pkg::DIR_IDLE) begin
          r.status = ers_pkg::ST_NOTHING;
        end else begin
          qsel = (car_dir_m == ers_pkg::DIR_UP) ? ers_pkg::QSEL_UP : ers_pkg::QSEL_DOWN;
          q_len[qsel] = q_len[qsel] - 1;
          car_floor_m = q_floor[qsel][q_len[qsel]];
          served = q_dest[qsel][q_len[qsel]];
          if (served[6] && served[5:0] != car_floor_m)
            void'(insert_call((served[5:0] < car_floor_m) ? ers_pkg::QSEL_DOWN :
                                                            ers_pkg::QSEL_UP,
                              served[5:0], 7'd0));
          if (q_len[qsel] == 0) car_dir_m = ers_pkg::DIR_IDLE;
          r.status = ers_pkg::ST_MOVED;
        end
      end
      default: r.status = ers_pkg::ST_NOTHING;
    endcase
    r.to_floor = car_floor_m;
    r.travel_dir = car_dir_m;
    r.up_pending = 7'(q_len[ers_pkg::QSEL_UP]);
    r.down_pending = 7'(q_len[ers_pkg::QSEL_DOWN]);
    return r;
  endfunction

  task automatic offer(input call_item_t it, input logic typed, input move_report_t want);
    move_report_t predicted;
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= {3'b000, it.dval, it.dest, it.call};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = schedule_step(it);
    awaited_reports.push_back(typed ? want : predicted);
    accepted_requests++;
  endtask

  task automatic pace(input logic settle);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0 || settle) s_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
    if (settle)
      while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    move_report_t got;
    move_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = move_report_t'(m_tdata[30:0]);
      if (awaited_reports.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("status", int'(want.status), int'(got.status));
        check_field("from_floor", int'(want.from_floor), int'(got.from_floor));
        check_field("to_floor", int'(want.to_floor), int'(got.to_floor));
        check_field("travel_dir", int'(want.travel_dir), int'(got.travel_dir));
        check_field("up_pending", int'(want.up_pending), int'(got.up_pending));
        check_field("down_pending", int'(want.down_pending), int'(got.down_pending));
      end
    end
  end

  initial begin
    logic held;
    int run;
    int stall;
    held = 1'b0;
    forever begin
      if (!held && accepted_requests >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        run = $urandom_range(1, 30);
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        m_tready <= 1'b1;
        repeat (run) @(posedge clk);
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("elevator_request_scheduler_tb: errors");
    $finish;
  end

  initial begin
    call_item_t it;
    int order [ers_pkg::QUEUE_DEPTH];
    int j;
    int t;
    int call_pct;
    int roll;
    q_len[ers_pkg::QSEL_UP] = 0;
    q_len[ers_pkg::QSEL_DOWN] = 0;
    car_floor_m = '0;
    car_dir_m = ers_pkg::DIR_IDLE;
    call_pct = 50;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      it = '{script[i].op, script[i].call, script[i].dest, script[i].dval};
      offer(it, script[i].typed, script[i].want);
      pace(1'b0);
    end

    // Fill each queue to full depth in shuffled order, then knock on it again.
    for (int q = 0; q < 2; q++) begin
      for (int i = 0; i < ers_pkg::QUEUE_DEPTH; i++) order[i] = i;
      for (int i = ers_pkg::QUEUE_DEPTH - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 0; i < ers_pkg::QUEUE_DEPTH + 6; i++) begin
        it.op = (q == 0) ? ers_pkg::OP_UP_CALL : ers_pkg::OP_DOWN_CALL;
        it.call = (i < ers_pkg::QUEUE_DEPTH) ? 6'(order[i]) : 6'($urandom_range(0, 63));
        it.dest = 6'($urandom);
        it.dval = 1'($urandom);
        offer(it, 1'b0, '0);
        pace(1'b0);
      end
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: call_pct = 85;
          1: call_pct = 50;
          default: call_pct = 20;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) it.op = OP_UNUSED;
      else if (roll < call_pct)
        it.op = $urandom_range(0, 1) ? ers_pkg::OP_DOWN_CALL : ers_pkg::OP_UP_CALL;
      else it.op = ers_pkg::OP_SERVE;
      it.call = 6'($urandom);
      it.dest = 6'($urandom);
      it.dval = 1'($urandom);
      offer(it, 1'b0, '0);
      if (n < RANDOM_REQUESTS - 1) pace(n == SETTLE_AT);
    end
    s_tvalid <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("elevator_request_scheduler_tb: clean");
    end else begin
      $display("elevator_request_scheduler_tb: errors");
    end
    $finish;
  end

endmodule
